@@ src/p1305_pkg.sv @@
// ----------------------------------------------------------------------------
// p1305_pkg
// Shared types, constants and helper functions for the Poly1305 block.
// ----------------------------------------------------------------------------
package p1305_pkg;

  localparam int NLIMB   = 5;
  localparam int LIMB_W  = 26;
  localparam int ACC_W   = 27;
  localparam int H_W     = 28;
  localparam int COEF_W  = 29;
  localparam int PROD_W  = H_W + COEF_W;
  localparam int D_W     = 62;
  localparam int F_W     = 28;
  localparam int KEY_W   = 64;
  localparam int CNT_W   = 5;

  localparam logic [KEY_W-1:0]  R_CLAMP_LO  = 64'h0ffffffc0fffffff;
  localparam logic [KEY_W-1:0]  R_CLAMP_HI  = 64'h0ffffffc0ffffffc;
  localparam logic [LIMB_W-1:0] FULL_TOP    = 26'h1000000;
  localparam logic [D_W-1:0]    LIMB_MASK_D = D_W'(26'h3ffffff);
  localparam logic [F_W-1:0]    LIMB_MASK_F = F_W'(26'h3ffffff);
  localparam logic [F_W-1:0]    LIMB_TOP_F  = F_W'(27'h4000000);
  localparam logic [F_W-1:0]    FIVE_F      = F_W'(3'd5);

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_R_LOW  = 2'd0;
  localparam cfg_idx_t CFG_R_HIGH = 2'd1;
  localparam cfg_idx_t CFG_S_LOW  = 2'd2;
  localparam cfg_idx_t CFG_S_HIGH = 2'd3;

  typedef logic [NLIMB-1:0][LIMB_W-1:0] limbs_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CARRY,
    ST_STORE,
    ST_FLOAD,
    ST_FCARRY,
    ST_FSEL,
    ST_FTAG
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_CARRY,
    OP_WRAP,
    OP_STORE,
    OP_FLOAD,
    OP_FSEL,
    OP_TAG
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic blk_empty;
    logic blk_last;
  } dp_status_t;

  // Splits a 130-bit little-endian value into five 26-bit limbs.
  function automatic limbs_t split_limbs(input logic [KEY_W-1:0] lo,
                                         input logic [KEY_W-1:0] hi,
                                         input logic [LIMB_W-1:0] top);
    limbs_t v;
    v[0] = lo[25:0];
    v[1] = lo[51:26];
    v[2] = {hi[13:0], lo[63:52]};
    v[3] = hi[39:14];
    v[4] = {2'b00, hi[63:40]} | top;
    return v;
  endfunction

endpackage

@@ src/p1305_if.sv @@
// ----------------------------------------------------------------------------
// p1305_if
// Valid/ready channel interfaces for message blocks and tags.
// ----------------------------------------------------------------------------
interface p1305_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_low;
  logic [63:0] block_high;
  logic [4:0]  byte_count;
  logic        is_last;

  modport source (output valid, block_low, block_high, byte_count, is_last, input ready);
  modport sink   (input valid, block_low, block_high, byte_count, is_last, output ready);
endinterface

interface p1305_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] tag_low;
  logic [63:0] tag_high;

  modport source (output valid, tag_low, tag_high, input ready);
  modport sink   (input valid, tag_low, tag_high, output ready);
endinterface

@@ src/poly1305_mac_top.sv @@
// ----------------------------------------------------------------------------
// poly1305_mac_top
// Poly1305 one-time authenticator with key registers and valid/ready channels.
// ----------------------------------------------------------------------------
// Write r and s through the cfg port while the block is idle, then send the
// message as 16-byte items; the item flagged last returns one 128-bit tag and
// clears the accumulator. A block item goes from acceptance through the
// five-lane limb multiplier (one product column per cycle), six carry steps on
// the shared carry unit and one store before the next item is accepted. A last
// item then adds the final reduction and the pad addition. An empty last item
// goes straight to the final reduction, and an empty item that is not last is
// taken with no effect. The tag sits in an output
// register, so new items are accepted while it waits to be taken; the final
// step of a later tag waits for as long as an earlier tag stays untaken.
// ----------------------------------------------------------------------------
module poly1305_mac_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  p1305_pkg::cfg_idx_t          cfg_index,
  input  logic [p1305_pkg::KEY_W-1:0]  cfg_wdata,
  p1305_in_if.sink                     in_ch,
  p1305_out_if.source                  out_ch
);
  import p1305_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  p1305_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  p1305_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_block_low  (in_ch.block_low),
    .in_block_high (in_ch.block_high),
    .in_byte_count (in_ch.byte_count),
    .in_is_last    (in_ch.is_last),
    .cmd           (cmd),
    .status        (status),
    .out_tag_low   (out_ch.tag_low),
    .out_tag_high  (out_ch.tag_high)
  );

endmodule

@@ src/p1305_ctrl.sv @@
// ----------------------------------------------------------------------------
// p1305_ctrl
// Sequencer for the Poly1305 datapath: handshakes, step counting and the
// output valid flag.
// ----------------------------------------------------------------------------
module p1305_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  p1305_pkg::dp_status_t status,
  output p1305_pkg::dp_cmd_t    cmd
);
  import p1305_pkg::*;

  ctrl_state_t      state_r, state_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  // The tag register may be overwritten once it is empty or being taken.
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.idx       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op   = OP_LOAD;
          last_nxt = status.blk_last;
          cnt_nxt  = '0;
          if (!status.blk_empty) begin
            state_nxt = ST_MUL;
          end else if (status.blk_last) begin
            state_nxt = ST_FLOAD;
          end
        end
      end
      ST_MUL: begin
        cmd.op  = OP_MUL;
        cmd.idx = cnt_r;
        if (cnt_r == 3'd4) begin
          cnt_nxt   = '0;
          state_nxt = ST_CARRY;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_CARRY: begin
        // Carry limbs 0 to 3, fold limb 4 back into limb 0, then carry limb 0.
        if (cnt_r == 3'd4) begin
          cmd.op = OP_WRAP;
        end else begin
          cmd.op  = OP_CARRY;
          cmd.idx = (cnt_r == 3'd5) ? 3'd0 : cnt_r;
        end
        if (cnt_r == 3'd5) begin
          cnt_nxt   = '0;
          state_nxt = ST_STORE;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_STORE: begin
        cmd.op    = OP_STORE;
        state_nxt = last_r ? ST_FLOAD : ST_IDLE;
      end
      ST_FLOAD: begin
        cmd.op    = OP_FLOAD;
        cnt_nxt   = '0;
        state_nxt = ST_FCARRY;
      end
      ST_FCARRY: begin
        // Final reduction carries limbs 1 to 3, folds limb 4, then carries limb 0.
        if (cnt_r == 3'd3) begin
          cmd.op = OP_WRAP;
        end else begin
          cmd.op  = OP_CARRY;
          cmd.idx = (cnt_r == 3'd4) ? 3'd0 : cnt_r + 3'd1;
        end
        if (cnt_r == 3'd4) begin
          cnt_nxt   = '0;
          state_nxt = ST_FSEL;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_FSEL: begin
        cmd.op    = OP_FSEL;
        state_nxt = ST_FTAG;
      end
      ST_FTAG: begin
        if (out_free) begin
          cmd.op        = OP_TAG;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

endmodule

@@ src/p1305_dp.sv @@
// ----------------------------------------------------------------------------
// p1305_dp
// Poly1305 datapath: key registers, block padding, five-lane limb
// multiplier, carry unit, final reduction and tag register.
// ----------------------------------------------------------------------------
module p1305_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  p1305_pkg::cfg_idx_t               cfg_index,
  input  logic [p1305_pkg::KEY_W-1:0]       cfg_wdata,
  input  logic [63:0]                       in_block_low,
  input  logic [63:0]                       in_block_high,
  input  logic [4:0]                        in_byte_count,
  input  logic                              in_is_last,
  input  p1305_pkg::dp_cmd_t                cmd,
  output p1305_pkg::dp_status_t             status,
  output logic [63:0]                       out_tag_low,
  output logic [63:0]                       out_tag_high
);
  import p1305_pkg::*;

  logic [KEY_W-1:0]  key_r_low_r, key_r_high_r, key_s_low_r, key_s_high_r;

  logic [ACC_W-1:0]  acc_r   [NLIMB];
  logic [ACC_W-1:0]  acc_nxt [NLIMB];
  logic [H_W-1:0]    h_r     [NLIMB];
  logic [H_W-1:0]    h_nxt   [NLIMB];
  logic [LIMB_W-1:0] r_r     [NLIMB];
  logic [LIMB_W-1:0] r_nxt   [NLIMB];
  logic [COEF_W-1:0] s_r     [NLIMB];
  logic [COEF_W-1:0] s_nxt   [NLIMB];
  logic [D_W-1:0]    d_r     [NLIMB];
  logic [D_W-1:0]    d_nxt   [NLIMB];
  logic [127:0]      fin_r, fin_nxt;
  logic [127:0]      tag_r, tag_nxt;

  logic [127:0]      pad;
  limbs_t            m_limbs;
  limbs_t            r_limbs;
  logic [H_W-1:0]    h_sel;
  logic [COEF_W-1:0] coef [NLIMB];
  logic [PROD_W-1:0] prod [NLIMB];
  logic [127:0]      fin_val;

  assign status.blk_empty = (in_byte_count == '0);
  assign status.blk_last  = in_is_last;
  assign out_tag_low      = tag_r[63:0];
  assign out_tag_high     = tag_r[127:64];

  // Key registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r_low_r  <= '0;
      key_r_high_r <= '0;
      key_s_low_r  <= '0;
      key_s_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_R_LOW:  key_r_low_r  <= cfg_wdata;
        CFG_R_HIGH: key_r_high_r <= cfg_wdata;
        CFG_S_LOW:  key_s_low_r  <= cfg_wdata;
        CFG_S_HIGH: key_s_high_r <= cfg_wdata;
      endcase
    end
  end

  // Bytes below the count pass, the byte at the count becomes 0x01 and the
  // rest are zero. A count of 16 or more keeps every byte and sets bit 128.
  always_comb begin
    for (int b = 0; b < 16; b++) begin
      if (5'(b) < in_byte_count) begin
        pad[8*b +: 8] = (b < 8) ? in_block_low[8*(b%8) +: 8] : in_block_high[8*(b%8) +: 8];
      end else if (5'(b) == in_byte_count) begin
        pad[8*b +: 8] = 8'h01;
      end else begin
        pad[8*b +: 8] = 8'h00;
      end
    end
    m_limbs = split_limbs(pad[63:0], pad[127:64], in_byte_count[4] ? FULL_TOP : '0);
    r_limbs = split_limbs(key_r_low_r & R_CLAMP_LO, key_r_high_r & R_CLAMP_HI, '0);
  end

  // Column j of the schoolbook product: lane i takes h[j] times r[i-j], or
  // times 5*r[i-j+5] where the index wraps past the top limb.
  always_comb begin
    h_sel = '0;
    for (int i = 0; i < NLIMB; i++) begin
      coef[i] = '0;
    end
    for (int j = 0; j < NLIMB; j++) begin
      if (cmd.idx == 3'(j)) begin
        h_sel = h_r[j];
        for (int i = 0; i < NLIMB; i++) begin
          coef[i] = (i >= j) ? COEF_W'(r_r[(i - j + NLIMB) % NLIMB])
                             : s_r[(i - j + NLIMB) % NLIMB];
        end
      end
    end
    for (int i = 0; i < NLIMB; i++) begin
      prod[i] = PROD_W'(h_sel) * PROD_W'(coef[i]);
    end
  end

  // Final step: try h + 5 - 2^130 and keep it when it does not borrow.
  always_comb begin
    logic [F_W-1:0] f   [NLIMB];
    logic [F_W-1:0] g   [NLIMB];
    logic [F_W-1:0] sel [NLIMB];
    logic [F_W-1:0] cc;
    logic           ge;
    logic [63:0]    lo;
    logic [63:0]    hi;
    for (int i = 0; i < NLIMB; i++) begin
      f[i] = d_r[i][F_W-1:0];
    end
    cc = FIVE_F;
    for (int i = 0; i < NLIMB - 1; i++) begin
      g[i] = f[i] + cc;
      cc   = g[i] >> LIMB_W;
      g[i] = g[i] & LIMB_MASK_F;
    end
    g[NLIMB-1] = f[NLIMB-1] + cc;
    ge = (g[NLIMB-1] >= LIMB_TOP_F);
    if (ge) begin
      g[NLIMB-1] = g[NLIMB-1] - LIMB_TOP_F;
    end
    for (int i = 0; i < NLIMB; i++) begin
      sel[i] = ge ? g[i] : f[i];
    end
    lo = 64'(sel[0]) | (64'(sel[1]) << 26) | (64'(sel[2]) << 52);
    hi = 64'(sel[2] >> 12) | (64'(sel[3]) << 14) | (64'(sel[4]) << 40);
    fin_val = {hi, lo};
  end

  always_comb begin
    logic [D_W-1:0] carry4;
    carry4  = d_r[NLIMB-1] >> LIMB_W;
    acc_nxt = acc_r;
    h_nxt   = h_r;
    r_nxt   = r_r;
    s_nxt   = s_r;
    d_nxt   = d_r;
    fin_nxt = fin_r;
    tag_nxt = tag_r;
    unique case (cmd.op)
      OP_LOAD: begin
        for (int i = 0; i < NLIMB; i++) begin
          h_nxt[i] = H_W'(acc_r[i]) + H_W'(m_limbs[i]);
          r_nxt[i] = r_limbs[i];
          s_nxt[i] = COEF_W'(r_limbs[i]) + (COEF_W'(r_limbs[i]) << 2);
        end
      end
      OP_MUL: begin
        for (int i = 0; i < NLIMB; i++) begin
          d_nxt[i] = ((cmd.idx == 3'd0) ? '0 : d_r[i]) + D_W'(prod[i]);
        end
      end
      OP_CARRY: begin
        for (int l = 0; l < NLIMB - 1; l++) begin
          if (cmd.idx == 3'(l)) begin
            d_nxt[l]     = d_r[l] & LIMB_MASK_D;
            d_nxt[l + 1] = d_r[l + 1] + (d_r[l] >> LIMB_W);
          end
        end
      end
      OP_WRAP: begin
        // 2^130 is congruent to 5, so the top carry returns to limb 0 times 5.
        d_nxt[NLIMB-1] = d_r[NLIMB-1] & LIMB_MASK_D;
        d_nxt[0]       = d_r[0] + carry4 + (carry4 << 2);
      end
      OP_STORE: begin
        for (int i = 0; i < NLIMB; i++) begin
          acc_nxt[i] = d_r[i][ACC_W-1:0];
        end
      end
      OP_FLOAD: begin
        for (int i = 0; i < NLIMB; i++) begin
          d_nxt[i] = D_W'(acc_r[i]);
        end
      end
      OP_FSEL: begin
        fin_nxt = fin_val;
      end
      OP_TAG: begin
        tag_nxt = fin_r + {key_s_high_r, key_s_low_r};
        for (int i = 0; i < NLIMB; i++) begin
          acc_nxt[i] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NLIMB; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r   <= h_nxt;
    r_r   <= r_nxt;
    s_r   <= s_nxt;
    d_r   <= d_nxt;
    fin_r <= fin_nxt;
    tag_r <= tag_nxt;
  end

endmodule

@@ test/tb_poly1305_mac_top.sv @@
// ----------------------------------------------------------------------------
// tb_poly1305_mac_top
// Self-checking bench for the Poly1305 MAC. Message items are sent on the
// input channel, and tags are checked against a bit-exact predictor of the
// 26-bit limb arithmetic. The bench runs several key settings, varies how
// often each side idles, and mixes directed corner blocks with random messages.
// ----------------------------------------------------------------------------
module tb_poly1305_mac_top;
  import p1305_pkg::*;

  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 142;
  localparam int          SETTLE      = 40;
  localparam int          LIMIT       = 500000;
  localparam logic [63:0] MASK26      = 64'h3ffffff;
  localparam logic [63:0] TOP26       = 64'h4000000;
  localparam logic [63:0] PAD_BIT     = 64'h1000000;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  cnt;
    logic        last;
  } msg_block_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } tag_t;

  typedef logic [4:0][63:0] wide_limbs_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [KEY_W-1:0] cfg_wdata;

  p1305_in_if  in_ch ();
  p1305_out_if out_ch ();

  poly1305_mac_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor state: key copies and the lazily carried accumulator.
  logic [63:0] key_r_lo, key_r_hi, key_s_lo, key_s_hi;
  logic [26:0] acc_limb [5];

  msg_block_t pending_blocks [$];
  tag_t       tag_q [$];
  msg_block_t cur_block;

  int send_idle_pct;
  int recv_idle_pct;
  int err_count;
  int cycles;
  int items_added;
  int paused;

  function automatic wide_limbs_t split26(logic [63:0] lo, logic [63:0] hi,
                                          logic [63:0] top);
    wide_limbs_t v;
    v[0] = lo & MASK26;
    v[1] = (lo >> 26) & MASK26;
    v[2] = ((lo >> 52) | (hi << 12)) & MASK26;
    v[3] = (hi >> 14) & MASK26;
    v[4] = (hi >> 40) | top;
    return v;
  endfunction

  // h = (h + m) * r mod 2^130-5, with the same partial carry chain as the block.
  function automatic void mac_absorb(logic [63:0] lo, logic [63:0] hi, logic [63:0] top);
    wide_limbs_t m, r, h, d, r5;
    logic [63:0] c;
    m = split26(lo, hi, top);
    r = split26(key_r_lo & R_CLAMP_LO, key_r_hi & R_CLAMP_HI, 64'd0);
    for (int i = 0; i < 5; i++) begin
      h[i]  = 64'(acc_limb[i]) + m[i];
      r5[i] = r[i] * 64'd5;
    end
    for (int i = 0; i < 5; i++) begin
      d[i] = 64'd0;
      for (int j = 0; j < 5; j++) begin
        if (i >= j) begin
          d[i] += h[j] * r[i-j];
        end else begin
          d[i] += h[j] * r5[i-j+5];
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      c = d[i] >> 26;
      d[i] &= MASK26;
      d[i+1] += c;
    end
    c = d[4] >> 26;
    d[4] &= MASK26;
    d[0] += c * 64'd5;
    c = d[0] >> 26;
    d[0] &= MASK26;
    d[1] += c;
    for (int i = 0; i < 5; i++) acc_limb[i] = d[i][26:0];
  endfunction

  function automatic tag_t mac_tag();
    wide_limbs_t h, g;
    logic [63:0] c, lo, hi, sum;
    tag_t t;
    for (int i = 0; i < 5; i++) h[i] = 64'(acc_limb[i]);
    // The first carry pass starts at limb 1, as each absorb already leaves limb 0 within 26 bits.
    for (int i = 1; i < 4; i++) begin
      c = h[i] >> 26;
      h[i] &= MASK26;
      h[i+1] += c;
    end
    c = h[4] >> 26;
    h[4] &= MASK26;
    h[0] += c * 64'd5;
    c = h[0] >> 26;
    h[0] &= MASK26;
    h[1] += c;
    c = 64'd5;
    for (int i = 0; i < 4; i++) begin
      g[i] = h[i] + c;
      c = g[i] >> 26;
      g[i] &= MASK26;
    end
    g[4] = h[4] + c;
    if (g[4] >= TOP26) begin
      g[4] -= TOP26;
      h = g;
    end
    lo = h[0] | (h[1] << 26) | (h[2] << 52);
    hi = (h[2] >> 12) | (h[3] << 14) | (h[4] << 40);
    sum = lo + key_s_lo;
    t.lo = sum;
    t.hi = hi + key_s_hi + ((sum < lo) ? 64'd1 : 64'd0);
    return t;
  endfunction

  function automatic void mac_step(msg_block_t b);
    int n;
    logic [63:0] lo, hi;
    n  = int'(b.cnt);
    lo = b.lo;
    hi = b.hi;
    if (n > 16) n = 16;
    if (n == 16) begin
      mac_absorb(lo, hi, PAD_BIT);
    end else if (n > 0) begin
      if (n < 8) begin
        lo &= (64'd1 << (8 * n)) - 64'd1;
        lo |= 64'd1 << (8 * n);
        hi = 64'd0;
      end else begin
        hi &= (64'd1 << (8 * (n - 8))) - 64'd1;
        hi |= 64'd1 << (8 * (n - 8));
      end
      mac_absorb(lo, hi, 64'd0);
    end
    if (b.last) begin
      tag_q.push_back(mac_tag());
      for (int i = 0; i < 5; i++) acc_limb[i] = '0;
    end
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_block(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt, logic last);
    msg_block_t b;
    b.lo   = lo;
    b.hi   = hi;
    b.cnt  = cnt;
    b.last = last;
    pending_blocks.push_back(b);
    items_added++;
  endtask

  // Mostly well-formed messages; the rest is random counts and flags.
  task automatic add_random_message();
    int nfull;
    int nnoise;
    if ($urandom_range(99) < 80) begin
      nfull = ($urandom_range(19) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
      for (int i = 0; i < nfull; i++) add_block(rand_word(), rand_word(), 5'd16, 1'b0);
      add_block(rand_word(), rand_word(), 5'($urandom_range(0, 16)), 1'b1);
    end else begin
      nnoise = $urandom_range(1, 3);
      for (int i = 0; i < nnoise; i++) begin
        add_block(rand_word(), rand_word(), 5'($urandom_range(0, 31)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_blocks.size() != 0 || in_ch.valid || tag_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_key(cfg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_R_LOW:  key_r_lo = val;
      CFG_R_HIGH: key_r_hi = val;
      CFG_S_LOW:  key_s_lo = val;
      CFG_S_HIGH: key_s_hi = val;
      default: ;
    endcase
  endtask

  task automatic load_keys(logic [63:0] rl, logic [63:0] rh, logic [63:0] sl,
                           logic [63:0] sh);
    write_key(CFG_R_LOW, rl);
    write_key(CFG_R_HIGH, rh);
    write_key(CFG_S_LOW, sl);
    write_key(CFG_S_HIGH, sh);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_directed();
    add_block(64'd0, 64'd0, 5'd16, 1'b1);
    add_block('1, '1, 5'd16, 1'b0);
    add_block('1, '1, 5'd16, 1'b1);
    // Empty last block on a cleared accumulator: the tag is the pad alone.
    add_block('1, '1, 5'd0, 1'b1);
    // An empty block that is not last must leave the state alone.
    add_block(rand_word(), rand_word(), 5'd0, 1'b0);
    add_block('1, '1, 5'd0, 1'b1);
    // Every short length, some of them in the middle of a message.
    for (int n = 1; n < 16; n++) add_block('1, '1, 5'(n), 1'(n % 3 == 0));
    add_block('1, '1, 5'd17, 1'b0);
    add_block('1, '1, 5'd31, 1'b1);
    add_block('1, '1, 5'd16, 1'b0);
    add_block(64'd0, 64'd0, 5'd0, 1'b1);
  endtask

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Input driver: predicts on acceptance, then refills from the pending queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) mac_step(cur_block);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_block = pending_blocks.pop_front();
          in_ch.block_low  <= cur_block.lo;
          in_ch.block_high <= cur_block.hi;
          in_ch.byte_count <= cur_block.cnt;
          in_ch.is_last    <= cur_block.last;
          in_ch.valid      <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Tag monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (tag_q.size() == 0) begin
          if (err_count < 40) begin
            $display("%0t unexpected tag: expected none actual %h_%h", $time,
                     out_ch.tag_high, out_ch.tag_low);
          end
          err_count++;
        end else begin
          if (out_ch.tag_low !== tag_q[0].lo) begin
            if (err_count < 40) begin
              $display("%0t tag_low mismatch: expected %h actual %h", $time,
                       tag_q[0].lo, out_ch.tag_low);
            end
            err_count++;
          end
          if (out_ch.tag_high !== tag_q[0].hi) begin
            if (err_count < 40) begin
              $display("%0t tag_high mismatch: expected %h actual %h", $time,
                       tag_q[0].hi, out_ch.tag_high);
            end
            err_count++;
          end
          void'(tag_q.pop_front());
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_R_LOW;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.block_low  = '0;
    in_ch.block_high = '0;
    in_ch.byte_count = '0;
    in_ch.is_last    = 1'b0;
    out_ch.ready     = 1'b0;
    err_count        = 0;
    cycles           = 0;
    items_added      = 0;
    paused           = 0;
    send_idle_pct    = 11;
    recv_idle_pct    = 61;
    key_r_lo = '0;
    key_r_hi = '0;
    key_s_lo = '0;
    key_s_hi = '0;
    for (int i = 0; i < 5; i++) acc_limb[i] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      send_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 61 : 0;
      recv_idle_pct = (ph < 2) ? 61 : (ph < 4) ? 11 : 0;
      case (ph)
        0: load_keys('1, '1, '1, '1);
        1: load_keys('0, '0, '0, '0);
        2: load_keys(rand_word(), rand_word(), '1, '1);
        default: load_keys({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      items_added = 0;
      if (ph == 0) add_directed();
      while (items_added < PHASE_ITEMS) begin
        add_random_message();
        // Hold the sender once until every tag so far has been taken.
        if (ph == 2 && paused == 0 && items_added >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1;
        end
      end
      // Close any message left open by noise items before the keys change.
      add_block(rand_word(), rand_word(), 5'd16, 1'b1);
    end

    wait_drained();
    if (err_count == 0 && tag_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/p1305_pkg.sv
src/p1305_if.sv
src/p1305_ctrl.sv
src/p1305_dp.sv
src/poly1305_mac_top.sv
test/tb_poly1305_mac_top.sv
